// ===== rtl/phi_pkg.sv =====
// Shared types and constants for the pixel hue inversion block.
package phi_pkg;

  // Default number of fraction bits of the fixed-point hue.
  localparam int unsigned HueFracBitsDef = 8;

  // floor(2^16 / 15): the reciprocal used to divide the scaled product by 15.
  localparam logic [15:0] Recip15 = 16'd4369;
  localparam logic [11:0] XDivisor = 12'd15;

  // Hue sector offset chosen from which component is the minimum.
  typedef enum logic [1:0] {
    OFS_GREY,
    OFS_60,
    OFS_180,
    OFS_300
  } hue_ofs_e;

  // Per-pixel data that travels beside the hue computation.
  typedef struct packed {
    logic [7:0] vmax;
    logic [7:0] chroma;
    logic       neg;
    hue_ofs_e   ofs;
  } pix_side_t;

endpackage

// ===== rtl/pixel_hue_inversion.sv =====
// Pixel hue inversion: turns the hue of an 8-bit RGB pixel by 180 degrees.
//
// Usage:
//   An input transfer happens at a rising edge of clk_i with start_i high and
//   busy_o low. busy_o is always low, so one pixel can be taken every cycle.
//   Each result is shown on red_out_o, green_out_o and blue_out_o for exactly
//   one cycle with valid_o high, and is taken at the edge that ends it.
//   Results leave in the order in which the pixels came in.
// Pipeline:
//   The depth is set by the restoring divider for the hue, which settles one
//   quotient bit per stage over HueFracBits + 6 stages, plus nine stages for
//   max/min, divider seed, hue offset, rotation, sector, weight, product,
//   scale and output. Throughput is one pixel per clock.
// Reset:
//   rst_ni clears every valid bit at once; data registers are not reset.
//   There is no clearing pass and the block can take pixels right after reset.
// Stalls:
//   The receiver cannot hold results off, so the pipeline never stalls.
module pixel_hue_inversion #(
  parameter int unsigned HueFracBits = phi_pkg::HueFracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       valid_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);
  import phi_pkg::*;

  // Quotient width, hue width, sector-local hue width and product width.
  localparam int unsigned QW = HueFracBits + 6;
  localparam int unsigned HW = HueFracBits + 9;
  localparam int unsigned TW = HueFracBits + 7;
  localparam int unsigned PW = HueFracBits + 14;

  localparam logic [HW-1:0] Hue60  = HW'(60 << HueFracBits);
  localparam logic [HW-1:0] Hue120 = HW'(120 << HueFracBits);
  localparam logic [HW-1:0] Hue180 = HW'(180 << HueFracBits);
  localparam logic [HW-1:0] Hue240 = HW'(240 << HueFracBits);
  localparam logic [HW-1:0] Hue300 = HW'(300 << HueFracBits);
  localparam logic [HW-1:0] Hue360 = HW'(360 << HueFracBits);

  // The block never pushes back.
  assign busy_o = 1'b0;

  logic in_xfer;
  assign in_xfer = start_i && !busy_o;

  // ---------------------------------------------------------------------
  // Stage 1: max, min, chroma and the signed difference for the hue.
  // ---------------------------------------------------------------------
  logic [7:0] mx, mn, dabs;
  pix_side_t  s1_side_d;

  always_comb begin
    mx = (blue_in_i > green_in_i) ? blue_in_i : green_in_i;
    if (red_in_i > mx) begin
      mx = red_in_i;
    end
    mn = (blue_in_i < green_in_i) ? blue_in_i : green_in_i;
    if (red_in_i < mn) begin
      mn = red_in_i;
    end
    s1_side_d.vmax   = mx;
    s1_side_d.chroma = mx - mn;
    // Ties for the minimum favor blue, then red.
    if (mx == mn) begin
      s1_side_d.ofs = OFS_GREY;
      s1_side_d.neg = 1'b0;
      dabs          = '0;
    end else if (mn == blue_in_i) begin
      s1_side_d.ofs = OFS_60;
      s1_side_d.neg = green_in_i < red_in_i;
      dabs = s1_side_d.neg ? red_in_i - green_in_i : green_in_i - red_in_i;
    end else if (mn == red_in_i) begin
      s1_side_d.ofs = OFS_180;
      s1_side_d.neg = blue_in_i < green_in_i;
      dabs = s1_side_d.neg ? green_in_i - blue_in_i : blue_in_i - green_in_i;
    end else begin
      s1_side_d.ofs = OFS_300;
      s1_side_d.neg = red_in_i < blue_in_i;
      dabs = s1_side_d.neg ? blue_in_i - red_in_i : red_in_i - blue_in_i;
    end
  end

  logic       s1_vld_q;
  pix_side_t  s1_side_q;
  logic [7:0] s1_dabs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= s1_side_d;
    s1_dabs_q <= dabs;
  end

  // ---------------------------------------------------------------------
  // Divider: |diff| * 60 * 2^F / chroma, one quotient bit per stage.
  // The quotient is below 2^QW, so the top eight dividend bits seed the
  // remainder and the rest shift in while quotient bits shift out.
  // ---------------------------------------------------------------------
  logic [13:0] nm;
  assign nm = 14'({s1_dabs_q, 6'b0}) - 14'({s1_dabs_q, 2'b0});

  logic            div_vld_q  [QW+1];
  logic [7:0]      div_rem_q  [QW+1];
  logic [QW-1:0]   div_acc_q  [QW+1];
  pix_side_t       div_side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q[0] <= 1'b0;
    end else begin
      div_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q[0]  <= nm[13:6];
    div_acc_q[0]  <= {nm[5:0], {HueFracBits{1'b0}}};
    div_side_q[0] <= s1_side_q;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [8:0] trial;
    logic [8:0] trial_sub;
    logic       qbit;

    assign trial     = {div_rem_q[k], div_acc_q[k][QW-1]};
    assign trial_sub = trial - {1'b0, div_side_q[k].chroma};
    assign qbit      = trial >= {1'b0, div_side_q[k].chroma};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k+1] <= 1'b0;
      end else begin
        div_vld_q[k+1] <= div_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      div_rem_q[k+1]  <= qbit ? trial_sub[7:0] : trial[7:0];
      div_acc_q[k+1]  <= {div_acc_q[k][QW-2:0], qbit};
      div_side_q[k+1] <= div_side_q[k];
    end
  end

  // ---------------------------------------------------------------------
  // Hue stage: add the sector offset to the signed quotient.
  // ---------------------------------------------------------------------
  logic [HW-1:0] hue_base, hue_quot, hue_d;

  always_comb begin
    hue_quot = HW'(div_acc_q[QW]);
    case (div_side_q[QW].ofs)
      OFS_60:  hue_base = Hue60;
      OFS_180: hue_base = Hue180;
      OFS_300: hue_base = Hue300;
      default: hue_base = '0;
    endcase
    // A grey pixel went through the divider with a zero divisor; its hue is 0.
    if (div_side_q[QW].ofs == OFS_GREY) begin
      hue_d = '0;
    end else if (div_side_q[QW].neg) begin
      hue_d = hue_base - hue_quot;
    end else begin
      hue_d = hue_base + hue_quot;
    end
  end

  logic          hue_vld_q;
  logic [HW-1:0] hue_q;
  pix_side_t     hue_side_q;

  // ---------------------------------------------------------------------
  // Rotation stage: add 180 degrees modulo 360.
  // ---------------------------------------------------------------------
  logic [HW:0]   rot_sum;
  logic [HW-1:0] rot_d;

  assign rot_sum = {1'b0, hue_q} + {1'b0, Hue180};
  assign rot_d   = (rot_sum >= {1'b0, Hue360}) ? HW'(rot_sum - {1'b0, Hue360})
                                               : rot_sum[HW-1:0];

  logic          rot_vld_q;
  logic [HW-1:0] rot_q;
  pix_side_t     rot_side_q;

  // ---------------------------------------------------------------------
  // Sector stage: sector number and hue within the 120 degree period.
  // ---------------------------------------------------------------------
  logic [2:0]    sect_d;
  logic [HW-1:0] tbase;

  always_comb begin
    if (rot_q >= Hue300) begin
      sect_d = 3'd5;
    end else if (rot_q >= Hue240) begin
      sect_d = 3'd4;
    end else if (rot_q >= Hue180) begin
      sect_d = 3'd3;
    end else if (rot_q >= Hue120) begin
      sect_d = 3'd2;
    end else if (rot_q >= Hue60) begin
      sect_d = 3'd1;
    end else begin
      sect_d = 3'd0;
    end
    if (sect_d >= 3'd4) begin
      tbase = Hue240;
    end else if (sect_d >= 3'd2) begin
      tbase = Hue120;
    end else begin
      tbase = '0;
    end
  end

  logic          sect_vld_q;
  logic [2:0]    sect_q;
  logic [TW-1:0] sect_t_q;
  pix_side_t     sect_side_q;

  // ---------------------------------------------------------------------
  // Weight stage: w = 60 - |t - 60| in hue units.
  // ---------------------------------------------------------------------
  logic [TW-1:0] sixty_t;
  logic [QW-1:0] dev, w_d;

  assign sixty_t = TW'(Hue60);
  assign dev = (sect_t_q >= sixty_t) ? QW'(sect_t_q - sixty_t) : QW'(sixty_t - sect_t_q);
  assign w_d = QW'(Hue60) - dev;

  logic          w_vld_q;
  logic [QW-1:0] w_q;
  logic [2:0]    w_sect_q;
  pix_side_t     w_side_q;

  // ---------------------------------------------------------------------
  // Product stage: chroma * w.
  // ---------------------------------------------------------------------
  logic          p_vld_q;
  logic [PW-1:0] p_q;
  logic [2:0]    p_sect_q;
  pix_side_t     p_side_q;

  // ---------------------------------------------------------------------
  // Scale stage: drop 2^F and 4, then estimate the quotient by 15.
  // ---------------------------------------------------------------------
  logic [11:0] z_d;
  logic [27:0] z_recip;

  assign z_d     = p_q[HueFracBits+13:HueFracBits+2];
  assign z_recip = 28'(z_d) * 28'(Recip15);

  logic        z_vld_q;
  logic [11:0] z_q;
  logic [7:0]  z_est_q;
  logic [2:0]  z_sect_q;
  pix_side_t   z_side_q;

  // ---------------------------------------------------------------------
  // Output stage: correct the estimate and rebuild the components.
  // ---------------------------------------------------------------------
  logic [11:0] z_rem;
  logic [7:0]  xval, vbase, red_d, green_d, blue_d;

  always_comb begin
    z_rem = z_q - 12'(z_est_q) * XDivisor;
    xval  = (z_rem >= XDivisor) ? z_est_q + 8'd1 : z_est_q;
    vbase = z_side_q.vmax - z_side_q.chroma;
    red_d   = vbase;
    green_d = vbase;
    blue_d  = vbase;
    case (z_sect_q)
      3'd0: begin
        red_d   = vbase + z_side_q.chroma;
        green_d = vbase + xval;
      end
      3'd1: begin
        red_d   = vbase + xval;
        green_d = vbase + z_side_q.chroma;
      end
      3'd2: begin
        green_d = vbase + z_side_q.chroma;
        blue_d  = vbase + xval;
      end
      3'd3: begin
        green_d = vbase + xval;
        blue_d  = vbase + z_side_q.chroma;
      end
      3'd4: begin
        red_d   = vbase + xval;
        blue_d  = vbase + z_side_q.chroma;
      end
      default: begin
        red_d   = vbase + z_side_q.chroma;
        blue_d  = vbase + xval;
      end
    endcase
  end

  logic       out_vld_q;
  logic [7:0] red_q, green_q, blue_q;

  // Valid bits of the stages after the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_vld_q  <= 1'b0;
      rot_vld_q  <= 1'b0;
      sect_vld_q <= 1'b0;
      w_vld_q    <= 1'b0;
      p_vld_q    <= 1'b0;
      z_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      hue_vld_q  <= div_vld_q[QW];
      rot_vld_q  <= hue_vld_q;
      sect_vld_q <= rot_vld_q;
      w_vld_q    <= sect_vld_q;
      p_vld_q    <= w_vld_q;
      z_vld_q    <= p_vld_q;
      out_vld_q  <= z_vld_q;
    end
  end

  // Data registers of the stages after the divider.
  always_ff @(posedge clk_i) begin
    hue_q       <= hue_d;
    hue_side_q  <= div_side_q[QW];
    rot_q       <= rot_d;
    rot_side_q  <= hue_side_q;
    sect_q      <= sect_d;
    sect_t_q    <= TW'(rot_q - tbase);
    sect_side_q <= rot_side_q;
    w_q         <= w_d;
    w_sect_q    <= sect_q;
    w_side_q    <= sect_side_q;
    p_q         <= PW'(w_side_q.chroma) * PW'(w_q);
    p_sect_q    <= w_sect_q;
    p_side_q    <= w_side_q;
    z_q         <= z_d;
    z_est_q     <= z_recip[23:16];
    z_sect_q    <= p_sect_q;
    z_side_q    <= p_side_q;
    red_q       <= red_d;
    green_q     <= green_d;
    blue_q      <= blue_d;
  end

  assign valid_o     = out_vld_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

`ifndef ASSERT_OFF
  // The hue before rotation stays within a full turn.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_vld_q |-> hue_q <= Hue360)
    else $error("hue out of range");

  // The rotated hue is reduced below a full turn.
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_vld_q |-> rot_q < Hue360)
    else $error("rotated hue not reduced");

  // A colored pixel never gives a quotient above 60 degrees.
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[QW] && (div_side_q[QW].chroma != 8'd0)
      |-> div_acc_q[QW] <= QW'(Hue60))
    else $error("divider quotient too large");

  // A grey pixel comes out grey.
  a_grey_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    z_vld_q && (z_side_q.chroma == 8'd0)
      |=> valid_o && (red_out_o == green_out_o) && (green_out_o == blue_out_o))
    else $error("grey pixel changed");

  // The largest component, the value, is kept.
  a_value_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    z_vld_q |=> (red_out_o == $past(z_side_q.vmax)) ||
                (green_out_o == $past(z_side_q.vmax)) ||
                (blue_out_o == $past(z_side_q.vmax)))
    else $error("value not kept");
`endif

endmodule
